[design/i2cbm_pkg.sv]
package i2cbm_pkg;

    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;
    localparam int SCALE_W    = 11;
    localparam int WAIT_W     = 13;
    localparam int UNITS_W    = 3;
    localparam int SCALE_MAX  = 1024;
    localparam int BIT_CNT_W  = 4;

    localparam logic REG_TICK_SCALE = 1'b0;

    localparam logic [2:0] CMD_CODE_START = 3'd1;
    localparam logic [2:0] CMD_CODE_STOP  = 3'd2;
    localparam logic [2:0] CMD_CODE_WRITE = 3'd3;
    localparam logic [2:0] CMD_CODE_READ  = 3'd4;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_sampled;
    } t_in_item;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_received;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       sda_sampled;
    } t_cmd_item;

    typedef enum logic [21:0] {
        PH_IDLE      = 22'h000001,
        PH_ST_SCL_HI = 22'h000002,
        PH_ST_SDA_HI = 22'h000004,
        PH_ST_SDA_LO = 22'h000008,
        PH_ST_SCL_LO = 22'h000010,
        PH_SP_SDA_LO = 22'h000020,
        PH_SP_SCL_HI = 22'h000040,
        PH_SP_SDA_HI = 22'h000080,
        PH_WR_BIT    = 22'h000100,
        PH_WR_SCL_HI = 22'h000200,
        PH_WR_SCL_LO = 22'h000400,
        PH_WA_SDA_HI = 22'h000800,
        PH_WA_SCL_HI = 22'h001000,
        PH_WA_SAMPLE = 22'h002000,
        PH_WA_SCL_LO = 22'h004000,
        PH_RD_SDA_HI = 22'h008000,
        PH_RD_SCL_HI = 22'h010000,
        PH_RD_SAMPLE = 22'h020000,
        PH_RD_SCL_LO = 22'h040000,
        PH_MA_SDA    = 22'h080000,
        PH_MA_SCL_HI = 22'h100000,
        PH_MA_SCL_LO = 22'h200000
    } t_phase;

    // length of each phase in timing units
    function automatic logic [UNITS_W-1:0] phase_units(input t_phase p);
        logic [UNITS_W-1:0] u;
        unique case (p)
            PH_WR_SCL_HI, PH_WA_SCL_LO, PH_RD_SCL_LO,
            PH_MA_SCL_HI, PH_MA_SCL_LO:                 u = 3'd5;
            PH_WR_SCL_LO, PH_WA_SAMPLE, PH_RD_SAMPLE:   u = 3'd2;
            PH_IDLE:                                    u = 3'd0;
            default:                                    u = 3'd3;
        endcase
        return u;
    endfunction

endpackage

[design/i2cbm_fifo.sv]
module i2cbm_fifo #(
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);
    t_data      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[design/i2cbm_front.sv]
module i2cbm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  i2cbm_pkg::t_in_item  i_item,
    output logic                 o_full,
    input  logic                 i_take,
    output logic                 o_empty,
    output i2cbm_pkg::t_cmd_item o_cmd
);
    import i2cbm_pkg::*;

    t_cmd_item w_cmd;

    // unknown codes behave like no command
    always_comb begin
        w_cmd.write_byte  = i_item.write_byte;
        w_cmd.send_ack    = i_item.send_ack;
        w_cmd.sda_sampled = i_item.sda_sampled;
        unique case (i_item.command)
            CMD_CODE_START: w_cmd.kind = CMD_START;
            CMD_CODE_STOP:  w_cmd.kind = CMD_STOP;
            CMD_CODE_WRITE: w_cmd.kind = CMD_WRITE;
            CMD_CODE_READ:  w_cmd.kind = CMD_READ;
            default:        w_cmd.kind = CMD_NONE;
        endcase
    end

    i2cbm_fifo #(.t_data(t_cmd_item)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (o_cmd),
        .o_empty (o_empty)
    );
endmodule

[design/i2cbm_back.sv]
module i2cbm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [i2cbm_pkg::SCALE_W-1:0]       i_eff_scale,
    input  logic                                i_valid,
    input  i2cbm_pkg::t_cmd_item                i_cmd,
    output logic                                o_take,
    input  logic                                i_out_full,
    output logic                                o_out_push,
    output i2cbm_pkg::t_out_item                o_out_item
);
    import i2cbm_pkg::*;

    t_phase                r_phase, n_phase;
    logic [BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [WAIT_W-1:0]     r_wait, n_wait;
    logic [7:0]            r_shift, n_shift;
    logic                  r_ack, n_ack;
    logic                  r_mack, n_mack;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic [7:0]            r_held, n_held;

    logic                  w_step;
    logic                  w_done;
    logic                  w_ent_en;
    t_phase                w_ent;
    logic [UNITS_W+SCALE_W-1:0] w_prod;

    assign w_step     = i_valid && !i_out_full;
    assign o_take     = w_step;
    assign o_out_push = w_step;

    assign w_prod = {{SCALE_W{1'b0}}, phase_units(w_ent)}
                  * {{UNITS_W{1'b0}}, i_eff_scale};

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_wait    = r_wait;
        n_shift   = r_shift;
        n_ack     = r_ack;
        n_mack    = r_mack;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_held    = r_held;
        w_done    = 1'b0;
        w_ent_en  = 1'b0;
        w_ent     = PH_IDLE;

        // advance the running command
        if (r_phase != PH_IDLE) begin
            if (r_wait != '0) begin
                n_wait = r_wait - 1'b1;
            end else begin
                w_ent_en = 1'b1;
                unique case (r_phase)
                    PH_ST_SCL_HI: w_ent = PH_ST_SDA_HI;
                    PH_ST_SDA_HI: w_ent = PH_ST_SDA_LO;
                    PH_ST_SDA_LO: w_ent = PH_ST_SCL_LO;
                    PH_SP_SDA_LO: w_ent = PH_SP_SCL_HI;
                    PH_SP_SCL_HI: w_ent = PH_SP_SDA_HI;
                    PH_WR_BIT:    w_ent = PH_WR_SCL_HI;
                    PH_WR_SCL_HI: w_ent = PH_WR_SCL_LO;
                    PH_WR_SCL_LO: begin
                        n_bit_cnt = r_bit_cnt + 1'b1;
                        w_ent = n_bit_cnt[3] ? PH_WA_SDA_HI : PH_WR_BIT;
                    end
                    PH_WA_SDA_HI: w_ent = PH_WA_SCL_HI;
                    PH_WA_SCL_HI: w_ent = PH_WA_SAMPLE;
                    PH_WA_SAMPLE: w_ent = PH_WA_SCL_LO;
                    PH_RD_SDA_HI: w_ent = PH_RD_SCL_HI;
                    PH_RD_SCL_HI: w_ent = PH_RD_SAMPLE;
                    PH_RD_SAMPLE: w_ent = PH_RD_SCL_LO;
                    PH_RD_SCL_LO: begin
                        n_bit_cnt = r_bit_cnt + 1'b1;
                        if (n_bit_cnt[3]) begin
                            n_held = r_shift;
                            w_ent  = PH_MA_SDA;
                        end else begin
                            w_ent  = PH_RD_SCL_HI;
                        end
                    end
                    PH_MA_SDA:    w_ent = PH_MA_SCL_HI;
                    PH_MA_SCL_HI: w_ent = PH_MA_SCL_LO;
                    default: begin
                        // last phase of a command
                        w_ent_en = 1'b0;
                        n_phase  = PH_IDLE;
                        w_done   = 1'b1;
                    end
                endcase
            end
        end

        // a command is started whenever the engine is idle after this tick
        if (r_phase == PH_IDLE || w_done) begin
            unique case (i_cmd.kind)
                CMD_START: begin
                    w_ent_en = 1'b1;
                    w_ent    = PH_ST_SCL_HI;
                end
                CMD_STOP: begin
                    w_ent_en = 1'b1;
                    w_ent    = PH_SP_SDA_LO;
                end
                CMD_WRITE: begin
                    n_shift   = i_cmd.write_byte;
                    n_bit_cnt = '0;
                    w_ent_en  = 1'b1;
                    w_ent     = PH_WR_BIT;
                end
                CMD_READ: begin
                    n_mack    = i_cmd.send_ack;
                    n_bit_cnt = '0;
                    w_ent_en  = 1'b1;
                    w_ent     = PH_RD_SDA_HI;
                end
                default: ;
            endcase
        end

        if (w_ent_en) begin
            n_phase = w_ent;
            n_wait  = WAIT_W'(w_prod - 1'b1);
            unique case (w_ent)
                PH_ST_SCL_HI, PH_SP_SCL_HI, PH_WR_SCL_HI,
                PH_WA_SCL_HI, PH_RD_SCL_HI, PH_MA_SCL_HI:  n_scl = 1'b1;
                PH_ST_SCL_LO, PH_WA_SCL_LO, PH_RD_SCL_LO,
                PH_MA_SCL_LO:                               n_scl = 1'b0;
                PH_ST_SDA_HI, PH_SP_SDA_HI, PH_WA_SDA_HI,
                PH_RD_SDA_HI:                               n_sda = 1'b1;
                PH_ST_SDA_LO, PH_SP_SDA_LO:                 n_sda = 1'b0;
                PH_WR_BIT:    n_sda = n_shift[7];
                PH_WR_SCL_LO: begin
                    n_scl   = 1'b0;
                    n_shift = {n_shift[6:0], 1'b0};
                end
                PH_WA_SAMPLE: n_ack   = !i_cmd.sda_sampled;
                PH_RD_SAMPLE: n_shift = {n_shift[6:0], i_cmd.sda_sampled};
                PH_MA_SDA:    n_sda   = !n_mack;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_out_item.scl_release  = n_scl;
        o_out_item.sda_release  = n_sda;
        o_out_item.busy_res     = (n_phase != PH_IDLE);
        o_out_item.done_res     = w_done;
        o_out_item.read_byte    = n_held;
        o_out_item.ack_received = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= '0;
            r_wait    <= '0;
            r_shift   <= '0;
            r_ack     <= 1'b0;
            r_mack    <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_held    <= '0;
        end else if (w_step) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_wait    <= n_wait;
            r_shift   <= n_shift;
            r_ack     <= n_ack;
            r_mack    <= n_mack;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_held    <= n_held;
        end
    end
endmodule

[design/i2c_bit_level_master_unit.sv]
// Bit-level I2C master engine, stepped by one item per timebase tick.
// Input queue: push/full with i_item (command, write byte, ack choice and the
// SDA level seen on that tick). Result queue: empty/pop with o_item (SCL and
// SDA release levels, busy, done pulse, last read byte, slave ack).
// Every accepted item yields exactly one result item, in order.
// An item pushed waits in the input queue; the engine takes it and writes its
// result to the result queue, which drives o_item. Throughput: one item per
// cycle while the result queue has room, set by the phase/counter update.
// A two-entry queue sits between the command classifier and the engine, and
// a two-entry result queue feeds the output; when pop stays low the result
// queue fills, the engine stalls, then the input queue fills and full rises.
// Accepted items are never dropped; a push while full is ignored.
// tick_scale (APB, address 0) scales every phase length; 0 acts as 1 and
// values above 1024 act as 1024. Write it only while the engine is idle.
// Reset (synchronous, active low) empties both queues, releases SCL and SDA,
// clears the engine state and sets tick_scale to 1.
module i2c_bit_level_master_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    input  i2cbm_pkg::t_in_item                   i_item,
    output logic                                  full,
    input  logic                                  pop,
    output i2cbm_pkg::t_out_item                  o_item,
    output logic                                  empty,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [i2cbm_pkg::PADDR_W-1:0]         paddr,
    input  logic [i2cbm_pkg::DATA_W-1:0]          pwdata,
    output logic [i2cbm_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready
);
    import i2cbm_pkg::*;

    logic [SCALE_W-1:0] r_tick_scale;
    logic [SCALE_W-1:0] r_eff_scale;
    logic [SCALE_W-1:0] w_wr_scale;
    logic               w_cfg_wr;

    logic               w_mid_empty;
    logic               w_mid_take;
    t_cmd_item          w_mid_cmd;
    logic               w_out_full;
    logic               w_out_push;
    t_out_item          w_out_item;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready
                     && (paddr[2] == REG_TICK_SCALE);
    assign w_wr_scale = pwdata[SCALE_W-1:0];
    assign prdata     = (paddr[2] == REG_TICK_SCALE)
                      ? {{(DATA_W-SCALE_W){1'b0}}, r_tick_scale} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_scale <= SCALE_W'(1);
            r_eff_scale  <= SCALE_W'(1);
        end else if (w_cfg_wr) begin
            r_tick_scale <= w_wr_scale;
            if (w_wr_scale == '0) begin
                r_eff_scale <= SCALE_W'(1);
            end else if (w_wr_scale > SCALE_W'(SCALE_MAX)) begin
                r_eff_scale <= SCALE_W'(SCALE_MAX);
            end else begin
                r_eff_scale <= w_wr_scale;
            end
        end
    end

    i2cbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (w_mid_take),
        .o_empty (w_mid_empty),
        .o_cmd   (w_mid_cmd)
    );

    i2cbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_scale (r_eff_scale),
        .i_valid     (!w_mid_empty),
        .i_cmd       (w_mid_cmd),
        .o_take      (w_mid_take),
        .i_out_full  (w_out_full),
        .o_out_push  (w_out_push),
        .o_out_item  (w_out_item)
    );

    i2cbm_fifo #(.t_data(t_out_item)) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_item),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (o_item),
        .o_empty (empty)
    );
endmodule
